FILE: rtl/deadline_task_timer_table_assert.svh
// assertion macros shared by the deadline task timer table rtl
// no dependencies; taken in by the controller and the datapath
`ifndef DEADLINE_TASK_TIMER_TABLE_ASSERT_SVH
`define DEADLINE_TASK_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every rising edge outside reset
`define DTT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("dtt assertion failed");
// expression must never be true outside reset
`define DTT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("dtt forbidden condition seen");
`else
`define DTT_ASSERT(lbl, clk, rstn, prop)
`define DTT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: rtl/dtt_pkg.sv
// shared constants and controller to datapath command and status types
// no dependencies
package dtt_pkg;

	localparam int NUM_TASKS_DEF = 16;
	localparam int ACTION_W      = 3;
	localparam int ID_W          = 4;
	localparam int INTERVAL_W    = 16;
	localparam int TIME_W        = 32;

	localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_RESCHED = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_FETCH   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CANCEL  = 3'd4;

	typedef struct packed {
		logic start;      // item taken, latch slot and clear fetch search
		logic do_tick;
		logic do_create;
		logic do_cancel;
		logic rd_period;  // read stored period for reschedule
		logic wr_resched; // write rescheduled deadline
		logic scan_rd;    // read next deadline during fetch search
		logic commit;     // disarm the chosen slot
		logic load_out;   // load the result register
	} dtt_cmd_t;

	typedef struct packed {
		logic scan_last;  // search pointer sits on the last slot
	} dtt_sts_t;

endpackage

FILE: rtl/dtt_ctrl.sv
// controller state machine for the deadline task timer table
// depends on dtt_pkg and deadline_task_timer_table_assert.svh
`include "deadline_task_timer_table_assert.svh"
module dtt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dtt_pkg::ACTION_W-1:0]   action,
	output logic                           out_valid,
	input  logic                           out_stall,
	input  dtt_pkg::dtt_sts_t              sts,
	output dtt_pkg::dtt_cmd_t              cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_RESCH  = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_COMMIT = 6'b010000,
		S_RES    = 6'b100000
	} dtt_state_t;

	dtt_state_t state_q, state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					if (action == dtt_pkg::ACT_TICK) begin
						cmd.do_tick = 1'b1;
						state_d     = S_RES;
					end else if (action == dtt_pkg::ACT_CREATE) begin
						cmd.do_create = 1'b1;
						state_d       = S_RES;
					end else if (action == dtt_pkg::ACT_RESCHED) begin
						cmd.rd_period = 1'b1;
						state_d       = S_RESCH;
					end else if (action == dtt_pkg::ACT_FETCH) begin
						state_d = S_SCAN;
					end else if (action == dtt_pkg::ACT_CANCEL) begin
						cmd.do_cancel = 1'b1;
						state_d       = S_RES;
					end else begin
						state_d = S_RES;
					end
				end
			end
			S_RESCH: begin
				cmd.wr_resched = 1'b1;
				state_d        = S_RES;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_RES;
			end
			S_RES: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DTT_ASSERT(a_out_from_res, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_RES))
	`DTT_ASSERT(a_drain_after_scan, clk, arst_n, (state_q == S_DRAIN) |-> $past(state_q == S_SCAN))
	`DTT_ASSERT(a_accept_leaves_idle, clk, arst_n, accept |=> (state_q != S_IDLE))

endmodule

FILE: rtl/dtt_dpath.sv
// datapath: clock, deadline and period memories, armed flags, fetch search
// depends on dtt_pkg and deadline_task_timer_table_assert.svh
`include "deadline_task_timer_table_assert.svh"
module dtt_dpath #(
	parameter int NUM_TASKS = dtt_pkg::NUM_TASKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dtt_pkg::dtt_cmd_t                cmd,
	output dtt_pkg::dtt_sts_t                sts,
	input  logic [dtt_pkg::ID_W-1:0]         task_id,
	input  logic [dtt_pkg::INTERVAL_W-1:0]   interval,
	output logic                             found,
	output logic [dtt_pkg::ID_W-1:0]         fetched_id,
	output logic                             any_armed
);

	localparam int IDX_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam int EXT_W = IDX_W + dtt_pkg::ID_W;
	localparam int TW    = dtt_pkg::TIME_W;
	localparam int PW    = dtt_pkg::INTERVAL_W;

	logic [TW-1:0]        dl_mem [NUM_TASKS];
	logic [PW-1:0]        per_mem [NUM_TASKS];

	logic [TW-1:0]        now_q;
	logic [NUM_TASKS-1:0] flags_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     slot_q;
	logic                 ok_q;
	logic [PW-1:0]        per_rd_q;
	logic [IDX_W-1:0]     ptr_q;
	logic                 v_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [TW-1:0]        dl_s1;
	logic                 have_q;
	logic [IDX_W-1:0]     best_q;
	logic [TW-1:0]        best_late_q;
	logic                 found_q;
	logic [dtt_pkg::ID_W-1:0] fid_q;
	logic                 any_q;

	logic [EXT_W-1:0]     id_ext;
	logic [EXT_W-1:0]     best_ext;
	logic [IDX_W-1:0]     slot_in;
	logic                 ok_in;
	logic                 dl_we;
	logic [IDX_W-1:0]     dl_wa;
	logic [PW-1:0]        add_per;
	logic [TW-1:0]        dl_wd;
	logic                 clr_en;
	logic [IDX_W-1:0]     clr_idx;
	logic [TW-1:0]        diff;
	logic [TW-1:0]        late;
	logic                 expired;
	logic                 hit;

	assign id_ext   = {{IDX_W{1'b0}}, task_id};
	assign slot_in  = id_ext[IDX_W-1:0];
	assign ok_in    = id_ext < EXT_W'(NUM_TASKS);
	assign best_ext = {{dtt_pkg::ID_W{1'b0}}, best_q};

	// create writes at the incoming slot, reschedule at the latched one
	assign dl_we   = (cmd.do_create && ok_in) || (cmd.wr_resched && ok_q);
	assign dl_wa   = cmd.do_create ? slot_in : slot_q;
	assign add_per = cmd.do_create ? interval : per_rd_q;
	assign dl_wd   = now_q + {{(TW - PW){1'b0}}, add_per};

	assign clr_en  = (cmd.do_cancel && ok_in) || (cmd.commit && have_q);
	assign clr_idx = cmd.do_cancel ? slot_in : best_q;

	// expired when deadline minus now is zero or negative
	assign diff    = dl_s1 - now_q;
	assign late    = now_q - dl_s1;
	assign expired = (diff == '0) || diff[TW-1];
	assign hit     = v_s1 && flags_q[idx_s1] && expired && (!have_q || (late > best_late_q));

	assign sts.scan_last = (ptr_q == IDX_W'(NUM_TASKS - 1));

	assign found      = found_q;
	assign fetched_id = fid_q;
	assign any_armed  = any_q;

	// memories and payload registers
	always_ff @(posedge clk) begin
		if (dl_we) begin
			dl_mem[dl_wa] <= dl_wd;
		end
		if (cmd.scan_rd) begin
			dl_s1  <= dl_mem[ptr_q];
			idx_s1 <= ptr_q;
		end
		if (cmd.do_create && ok_in) begin
			per_mem[slot_in] <= interval;
		end
		if (cmd.rd_period) begin
			per_rd_q <= per_mem[slot_in];
		end
		if (cmd.start) begin
			slot_q <= slot_in;
			ok_q   <= ok_in;
		end
		if (hit) begin
			best_q      <= idx_s1;
			best_late_q <= late;
		end else if (cmd.start) begin
			best_q      <= '0;
			best_late_q <= '0;
		end
		if (cmd.load_out) begin
			found_q <= have_q;
			fid_q   <= best_ext[dtt_pkg::ID_W-1:0];
			any_q   <= (cnt_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			flags_q <= '0;
			cnt_q   <= '0;
			ptr_q   <= '0;
			v_s1    <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			if (cmd.do_tick) begin
				now_q <= now_q + 1'b1;
			end
			if (dl_we) begin
				flags_q[dl_wa] <= 1'b1;
				if (!flags_q[dl_wa]) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (clr_en) begin
				flags_q[clr_idx] <= 1'b0;
				if (flags_q[clr_idx]) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (cmd.start) begin
				ptr_q <= '0;
			end else if (cmd.scan_rd) begin
				ptr_q <= ptr_q + 1'b1;
			end
			v_s1 <= cmd.scan_rd;
			if (cmd.start) begin
				have_q <= 1'b0;
			end else if (hit) begin
				have_q <= 1'b1;
			end
		end
	end

	`DTT_ASSERT(a_cnt_matches_flags, clk, arst_n, (cnt_q != '0) == (|flags_q))
	`DTT_ASSERT(a_commit_armed, clk, arst_n, (cmd.commit && have_q) |-> flags_q[best_q])
	`DTT_NEVER(a_best_in_range, clk, arst_n, have_q && (best_ext >= EXT_W'(NUM_TASKS)))

endmodule

FILE: rtl/deadline_task_timer_table.sv
// top level of the deadline task timer table
// depends on dtt_pkg, dtt_ctrl and dtt_dpath
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_stall  | action, task_id, interval
//  result  | out_valid / out_stall| found, fetched_id, any_armed
//
// each item gives one result; reschedule first reads the period, then writes its new deadline
// fetch is a search of the table: the deadline memory has one read port and
// the search walks it one slot a cycle, keeping the most overdue expired slot
// in_stall is high while an item is being worked on; the result register lets
// the next item be taken while an earlier result is still held by out_stall
// reset clears the clock and the armed flags; memories need no clearing pass
module deadline_task_timer_table #(
	parameter int NUM_TASKS = dtt_pkg::NUM_TASKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [dtt_pkg::ACTION_W-1:0]     action,
	input  logic [dtt_pkg::ID_W-1:0]         task_id,
	input  logic [dtt_pkg::INTERVAL_W-1:0]   interval,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found,
	output logic [dtt_pkg::ID_W-1:0]         fetched_id,
	output logic                             any_armed
);

	// command and status between sequencer and datapath
	dtt_pkg::dtt_cmd_t cmd;
	dtt_pkg::dtt_sts_t sts;

	// sequencer: decodes the action at acceptance and paces the search
	dtt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: millisecond clock, task memories, armed flags, result register
	dtt_dpath #(
		.NUM_TASKS (NUM_TASKS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.task_id    (task_id),
		.interval   (interval),
		.found      (found),
		.fetched_id (fetched_id),
		.any_armed  (any_armed)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the deadline task timer table: a table of
// directed items, then random action sequences checked by a local predictor
// depends on dtt_pkg and the rtl of deadline_task_timer_table only

module testbench;

	// no acceptance on either side for this many cycles means the block hung
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 700;
	// a fetch walks every slot, so allow two of them after the last result
	localparam int TAIL_CYCLES  = 2 * (dtt_pkg::NUM_TASKS_DEF + 4);

	// action codes the block must treat as no operation
	localparam logic [dtt_pkg::ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
	localparam logic [dtt_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [dtt_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

	// one input item, plus an optional result typed in by hand
	typedef struct packed {
		logic [dtt_pkg::ACTION_W-1:0]   act;
		logic [dtt_pkg::ID_W-1:0]       id;
		logic [dtt_pkg::INTERVAL_W-1:0] ival;
		logic                           fixed;
		logic                           exp_found;
		logic [dtt_pkg::ID_W-1:0]       exp_id;
		logic                           exp_armed;
	} timer_item_t;

	typedef struct packed {
		logic                     found;
		logic [dtt_pkg::ID_W-1:0] id;
		logic                     armed;
	} timer_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [dtt_pkg::ACTION_W-1:0]   action;
	logic [dtt_pkg::ID_W-1:0]       task_id;
	logic [dtt_pkg::INTERVAL_W-1:0] interval;
	logic                           out_valid;
	logic                           out_stall;
	logic                           found;
	logic [dtt_pkg::ID_W-1:0]       fetched_id;
	logic                           any_armed;

	// predictor copy of the table
	logic [dtt_pkg::TIME_W-1:0]        now_ms;
	logic [dtt_pkg::TIME_W-1:0]        deadlines [dtt_pkg::NUM_TASKS_DEF];
	logic [dtt_pkg::INTERVAL_W-1:0]    periods   [dtt_pkg::NUM_TASKS_DEF];
	logic [dtt_pkg::NUM_TASKS_DEF-1:0] armed;
	// slots that have had a create, so a reschedule never reads an unset period
	logic [dtt_pkg::NUM_TASKS_DEF-1:0] created;

	timer_result_t awaited_results [$];
	int            failures;
	int            idle_cycles;
	// when set both sides run flat out, with no gaps and no stalls
	bit            no_idle;

	// directed items: after reset, the extremes, every action, zero interval,
	// overwrite of an armed slot, ties and lateness ordering in a fetch
	timer_item_t directed_items [26] = '{
		// empty table straight after reset
		'{dtt_pkg::ACT_FETCH,   4'd0,  16'h0000, 1'b1, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_TICK,    4'd0,  16'hAAAA, 1'b1, 1'b0, 4'd0, 1'b0},
		// unused code with every field at its top
		'{ACT_SPARE_7,          4'd15, 16'hFFFF, 1'b1, 1'b0, 4'd0, 1'b0},
		// zero interval expires at once and is fetched straight back
		'{dtt_pkg::ACT_CREATE,  4'd0,  16'h0000, 1'b1, 1'b0, 4'd0, 1'b1},
		'{dtt_pkg::ACT_FETCH,   4'd0,  16'h0000, 1'b1, 1'b1, 4'd0, 1'b0},
		// longest interval is nowhere near expiry
		'{dtt_pkg::ACT_CREATE,  4'd15, 16'hFFFF, 1'b1, 1'b0, 4'd0, 1'b1},
		'{dtt_pkg::ACT_FETCH,   4'd0,  16'h0000, 1'b1, 1'b0, 4'd0, 1'b1},
		// create over an armed slot replaces period and deadline
		'{dtt_pkg::ACT_CREATE,  4'd15, 16'h0001, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_TICK,    4'd5,  16'h5555, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_FETCH,   4'd10, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		// reschedule of a disarmed slot
		'{dtt_pkg::ACT_RESCHED, 4'd15, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		// two slots on the same deadline, the lower one must go first
		'{dtt_pkg::ACT_CREATE,  4'd3,  16'h0002, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_CREATE,  4'd5,  16'h0002, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_CREATE,  4'd10, 16'h5555, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_TICK,    4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_TICK,    4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_FETCH,   4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_FETCH,   4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_FETCH,   4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		// the latest slot wins over a lower slot that is only just due
		'{dtt_pkg::ACT_CREATE,  4'd9,  16'h0001, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_TICK,    4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_TICK,    4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_CREATE,  4'd2,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_FETCH,   4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		// cancel of an armed slot and of one never used
		'{dtt_pkg::ACT_CANCEL,  4'd10, 16'h0000, 1'b0, 1'b0, 4'd0, 1'b0},
		'{dtt_pkg::ACT_CANCEL,  4'd4,  16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0}
	};

	deadline_task_timer_table u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.task_id    (task_id),
		.interval   (interval),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.fetched_id (fetched_id),
		.any_armed  (any_armed)
	);

	always #6 clk = ~clk;

	// applies one accepted item to the local copy of the table and returns
	// the result item the block must give for it
	function automatic timer_result_t advance_timer_table(timer_item_t it);
		timer_result_t              res;
		logic                       have;
		logic [dtt_pkg::ID_W-1:0]   best;
		logic [dtt_pkg::TIME_W-1:0] best_late;
		logic [dtt_pkg::TIME_W-1:0] diff;
		logic [dtt_pkg::TIME_W-1:0] late;
		res       = '0;
		have      = 1'b0;
		best      = '0;
		best_late = '0;
		case (it.act)
			dtt_pkg::ACT_TICK: begin
				now_ms = now_ms + 1;
			end
			dtt_pkg::ACT_CREATE: begin
				periods[it.id]   = it.ival;
				deadlines[it.id] = now_ms + dtt_pkg::TIME_W'(it.ival);
				armed[it.id]     = 1'b1;
				created[it.id]   = 1'b1;
			end
			dtt_pkg::ACT_RESCHED: begin
				deadlines[it.id] = now_ms + dtt_pkg::TIME_W'(periods[it.id]);
				armed[it.id]     = 1'b1;
			end
			dtt_pkg::ACT_FETCH: begin
				// expired when deadline minus now is zero or negative as signed
				for (int i = 0; i < dtt_pkg::NUM_TASKS_DEF; i++) begin
					diff = deadlines[i] - now_ms;
					late = now_ms - deadlines[i];
					if (armed[i] && (diff == '0 || diff[dtt_pkg::TIME_W-1])) begin
						if (!have || late > best_late) begin
							have      = 1'b1;
							best      = dtt_pkg::ID_W'(i);
							best_late = late;
						end
					end
				end
				if (have) begin
					armed[best] = 1'b0;
					res.found   = 1'b1;
					res.id      = best;
				end
			end
			dtt_pkg::ACT_CANCEL: begin
				armed[it.id] = 1'b0;
			end
			default: begin
			end
		endcase
		res.armed = |armed;
		return res;
	endfunction

	// random item: mostly short intervals so that deadlines really expire,
	// reschedule only on slots that have seen a create
	function automatic timer_item_t draw_timer_item();
		timer_item_t it;
		int          pick;
		int          span;
		it      = '0;
		it.id   = dtt_pkg::ID_W'($urandom_range(0, dtt_pkg::NUM_TASKS_DEF - 1));
		span    = $urandom_range(0, 9);
		if (span < 7)
			it.ival = dtt_pkg::INTERVAL_W'($urandom_range(0, 6));
		else if (span < 9)
			it.ival = dtt_pkg::INTERVAL_W'($urandom_range(0, 40));
		else
			it.ival = dtt_pkg::INTERVAL_W'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 30)
			it.act = dtt_pkg::ACT_TICK;
		else if (pick < 50)
			it.act = dtt_pkg::ACT_CREATE;
		else if (pick < 60)
			it.act = dtt_pkg::ACT_RESCHED;
		else if (pick < 82)
			it.act = dtt_pkg::ACT_FETCH;
		else if (pick < 92)
			it.act = dtt_pkg::ACT_CANCEL;
		else if (pick < 95)
			it.act = ACT_SPARE_5;
		else if (pick < 98)
			it.act = ACT_SPARE_6;
		else
			it.act = ACT_SPARE_7;
		if (it.act == dtt_pkg::ACT_RESCHED && !created[it.id]) begin
			// move to a slot that has a period, or create one
			if (created == '0) begin
				it.act = dtt_pkg::ACT_CREATE;
			end else begin
				while (!created[it.id])
					it.id = it.id + 1'b1;
			end
		end
		return it;
	endfunction

	// drives one item from a falling edge and holds it until it is taken;
	// leaves the caller on the falling edge after acceptance
	task automatic send_item(timer_item_t it);
		int            gap;
		timer_result_t res;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= it.act;
		task_id  <= it.id;
		interval <= it.ival;
		do
			@(posedge clk);
		while (in_stall);
		res = advance_timer_table(it);
		if (it.fixed)
			res = '{it.exp_found, it.exp_id, it.exp_armed};
		awaited_results.push_back(res);
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		timer_item_t it;
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		action    = dtt_pkg::ACT_TICK;
		task_id   = '0;
		interval  = '0;
		out_stall = 1'b0;
		no_idle   = 1'b0;
		failures  = 0;
		now_ms    = '0;
		armed     = '0;
		created   = '0;
		foreach (deadlines[i]) begin
			deadlines[i] = '0;
			periods[i]   = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_items[k])
			send_item(directed_items[k]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// one window in every 160 items runs with no idling at all
			no_idle = (n % 160) >= 120;
			if (n == RANDOM_ITEMS / 2) begin
				// hold the input back until the result queue has run dry
				in_valid <= 1'b0;
				do
					@(negedge clk);
				while (awaited_results.size() != 0);
			end
			it = draw_timer_item();
			send_item(it);
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d result items never arrived", $time, awaited_results.size());
			failures++;
		end
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side: random stall, then take one item and check it
	initial begin : result_sink
		int            hold;
		timer_result_t want;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 4);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			if (awaited_results.size() == 0) begin
				$display("%0t: result item with none expected, found %0b id %0d armed %0b",
					$time, found, fetched_id, any_armed);
				failures++;
			end else begin
				want = awaited_results.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0b, got %0b", $time, want.found, found);
					failures++;
				end
				if (fetched_id !== want.id) begin
					$display("%0t: fetched_id expected %0d, got %0d",
						$time, want.id, fetched_id);
					failures++;
				end
				if (any_armed !== want.armed) begin
					$display("%0t: any_armed expected %0b, got %0b",
						$time, want.armed, any_armed);
					failures++;
				end
			end
			@(negedge clk);
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dtt_pkg.sv
rtl/dtt_ctrl.sv
rtl/dtt_dpath.sv
rtl/deadline_task_timer_table.sv
tb/testbench.sv
